// ----- rtl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared widths, types and reset values of the median-of-three glitch filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int SAMPLE_W = 32;
  localparam int THRESH_W = 24;
  localparam int DIFF_W   = SAMPLE_W + 1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1000);

  // Two ring cells hold the older stored samples; the incoming request is the third.
  localparam logic [1:0] FILL_PRIME = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t filtered;
    logic    rejected;
  } result_t;

endpackage

// ----- rtl/mf3_cell.sv -----
// ----------------------------------------------------------------------------
// mf3_cell
// One ring cell: holds a stored sample and hands it to the next cell on shift.
// ----------------------------------------------------------------------------
module mf3_cell
  import mf3_pkg::*;
(
  input  logic    clk,
  input  logic    shift_en,
  input  sample_t din,
  output sample_t q
);

  sample_t q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= din;
    end
  end

  assign q = q_r;

endmodule

// ----- rtl/mf3_median.sv -----
// ----------------------------------------------------------------------------
// mf3_median
// Signed median of three samples, three compares and a select.
// ----------------------------------------------------------------------------
module mf3_median
  import mf3_pkg::*;
(
  input  sample_t a,
  input  sample_t b,
  input  sample_t c,
  output sample_t med
);

  logic a_gt_b;
  logic a_gt_c;
  logic b_gt_c;

  assign a_gt_b = (a > b);
  assign a_gt_c = (a > c);
  assign b_gt_c = (b > c);

  always_comb begin
    if (a_gt_b) begin
      if (b_gt_c) med = b;
      else        med = a_gt_c ? c : a;
    end else begin
      if (a_gt_c) med = a;
      else        med = b_gt_c ? c : b;
    end
  end

endmodule

// ----- rtl/glitch_rejecting_median3_filter.sv -----
// ----------------------------------------------------------------------------
// glitch_rejecting_median3_filter
// Median-of-three pressure filter that drops samples jumping too far.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed 32-bit pressure sample per request (in_tdata).
//   out_* : one result per input request; out_tdata is the filtered sample,
//           out_tuser flags a sample dropped as a glitch.
//   cfg_* : cfg_wr_en writes cfg_wr_data into the 24-bit glitch threshold.
//           Write only while the filter is idle.
// Timing:
//   The spike compare and three-input median are combinational between
//   the ring cells and the output or skid register. Throughput is one
//   sample per cycle while in_tready is high.
// Reset (rst_n low, synchronous): threshold returns to 1000, the ring is
//   marked empty and the output side is cleared. The first two samples are
//   passed through, the third primes the median.
// Backpressure: when out_tready is low, one more result is parked in a skid
//   register; in_tready drops only when that register is occupied.
// ----------------------------------------------------------------------------
module glitch_rejecting_median3_filter
  import mf3_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,    // [31:0] pressure_sample
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,   // [31:0] filtered_pressure
  output logic [0:0]          out_tuser,   // [0] sample_rejected
  input  logic                cfg_wr_en,
  input  logic [THRESH_W-1:0] cfg_wr_data
);

  logic [THRESH_W-1:0] thresh_r;
  logic [1:0]          fill_r, fill_nxt;
  logic                primed_r, primed_nxt;
  result_t             out_r, skid_r;
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;

  sample_t             sample, c0, c1, med;
  logic                in_acc, primed_now, near_last, store, shift_en;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]   mag;
  result_t             res;

  assign sample = sample_t'(in_tdata);
  assign in_tready = ~skid_valid_r;
  assign in_acc = in_tvalid & in_tready;

  // ring cells, newest first
  mf3_cell u_cell0 (.clk(clk), .shift_en(shift_en), .din(sample), .q(c0));
  mf3_cell u_cell1 (.clk(clk), .shift_en(shift_en), .din(c0),     .q(c1));

  mf3_median u_median (.a(sample), .b(c0), .c(c1), .med(med));

  assign diff = DIFF_W'(c0) - DIFF_W'(sample);
  assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign near_last = (mag < {{(DIFF_W-THRESH_W){1'b0}}, thresh_r});

  assign primed_now = primed_r | (fill_r == FILL_PRIME);
  assign store = ~primed_now | near_last;
  assign shift_en = in_acc & store;

  always_comb begin
    res.rejected = 1'b0;
    if (!primed_now) begin
      res.filtered = sample;
    end else if (near_last) begin
      res.filtered = med;
    end else begin
      res.filtered = c0;
      res.rejected = 1'b1;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    primed_nxt = primed_r;
    if (in_acc && !primed_r) begin
      if (fill_r == FILL_PRIME) primed_nxt = 1'b1;
      else                      fill_nxt = fill_r + 2'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc;
      end
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      fill_r <= 2'd0;
      primed_r <= 1'b0;
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      fill_r <= fill_nxt;
      primed_r <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_acc)  out_r <= res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_r.filtered;
  assign out_tuser = out_r.rejected;

endmodule

// ----- verif/glitch_rejecting_median3_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glitch_rejecting_median3_filter_tb
// Self-checking bench for the median-of-three glitch filter. A behavioral
// model of the ring, the write slot and the priming flag predicts one result
// per accepted request. Directed cases cover pass-through, priming, the
// threshold boundary and the 33-bit difference. Random streams follow the
// last stored sample under several thresholds, mostly with random idling on
// both sides; a separate run adds a long output hold-off.
// ----------------------------------------------------------------------------
module glitch_rejecting_median3_filter_tb;
  import mf3_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;
  logic [0:0]          out_tuser;
  logic                cfg_wr_en = 1'b0;
  logic [THRESH_W-1:0] cfg_wr_data = '0;

  glitch_rejecting_median3_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("glitch_rejecting_median3_filter regression: fail");
    $finish;
  end

  // Filter model state
  sample_t             ring [3];
  logic [1:0]          ring_slot;
  logic                ring_primed;
  logic [THRESH_W-1:0] glitch_thr;
  result_t             filtered_due [$];

  int unsigned         mismatches = 0;
  int unsigned         stall_left = 0;
  bit                  tx_gaps = 1'b1;
  bit                  rx_gaps = 1'b1;
  logic [THRESH_W-1:0] cur_thr = THRESH_RESET;

  function automatic sample_t median_of(input sample_t a, input sample_t b, input sample_t c);
    sample_t lo, hi, mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

  function automatic sample_t last_stored();
    return ring[(ring_slot == 2'd0) ? 2 : ring_slot - 2'd1];
  endfunction

  function automatic result_t filter_next_result(input sample_t s);
    logic [1:0]               nxt;
    sample_t                  last;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    result_t                  r;
    nxt  = (ring_slot == 2'd2) ? 2'd0 : ring_slot + 2'd1;
    last = last_stored();
    if (ring_slot == 2'd2) ring_primed = 1'b1;
    r.rejected = 1'b0;
    if (!ring_primed) begin
      ring[ring_slot] = s;
      ring_slot = nxt;
      r.filtered = s;
    end else begin
      diff = {last[SAMPLE_W-1], last} - {s[SAMPLE_W-1], s};
      mag  = diff[DIFF_W-1] ? -diff : diff;
      if (mag < {{(DIFF_W-THRESH_W){1'b0}}, glitch_thr}) begin
        ring[ring_slot] = s;
        ring_slot = nxt;
        r.filtered = median_of(ring[0], ring[1], ring[2]);
      end else begin
        r.filtered = last;
        r.rejected = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // Prediction and result check
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      ring        = '{default: '0};
      ring_slot   = 2'd0;
      ring_primed = 1'b0;
      glitch_thr  = THRESH_RESET;
      filtered_due.delete();
    end else begin
      if (cfg_wr_en) glitch_thr = cfg_wr_data;
      if (in_tvalid && in_tready) filtered_due.push_back(filter_next_result(in_tdata));
      if (out_tvalid && out_tready) begin
        if (filtered_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result %0d rej %0b",
                                  $signed(out_tdata), out_tuser[0]));
        end else begin
          want = filtered_due.pop_front();
          if (want.filtered !== out_tdata || want.rejected !== out_tuser[0])
            note_mismatch($sformatf("expected %0d rej %0b, got %0d rej %0b",
                                    want.filtered, want.rejected,
                                    $signed(out_tdata), out_tuser[0]));
        end
      end
    end
  end

  // Result side ready, with a counted hold-off on request
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= !(rx_gaps && $urandom_range(0, 99) < 7);
    end
  end

  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while (tx_gaps && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] thr);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    cur_thr      = thr;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic sample_t clamp_sample(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return sample_t'(v);
  endfunction

  // Mostly samples near the last stored one, some on the boundary, some glitches
  function automatic sample_t pick_sample();
    int unsigned r;
    longint      mag;
    longint      base;
    r    = $urandom_range(0, 99);
    base = longint'(last_stored());
    if (r < 3) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    if (r < 70) mag = (cur_thr == 0) ? 0 : $urandom_range(0, cur_thr - 1);
    else if (r < 85) mag = (cur_thr == 0) ? 0 : cur_thr - $urandom_range(0, 1);
    else if (r < 95) mag = longint'(cur_thr) + $urandom_range(0, 32'h00ffffff);
    else return sample_t'($urandom);
    return clamp_sample(($urandom_range(0, 1) != 0) ? base + mag : base - mag);
  endfunction

  task automatic test_priming_and_defaults();
    send_sample(32'sh80000000);
    send_sample(32'sh7fffffff);
    send_sample(32'sd0);            // primes while rejected
    send_sample(32'sd2147482999);
    send_sample(32'sh7fffffff);
    send_sample(32'sd2147482647);   // exactly at threshold
    send_sample(32'sd2147482648);
    send_sample(32'sd2147482648);
    settle();
  endtask

  task automatic test_threshold_edges();
    write_threshold(24'hffffff);
    send_sample(last_stored() - 32'sd16777215);
    send_sample(last_stored() - 32'sd16777214);
    send_sample(32'sh80000000);     // full-range jump, 33-bit difference
    send_sample(last_stored() + 32'sd16777214);
    settle();
    write_threshold(24'd0);
    send_sample(last_stored());
    send_sample(last_stored() + 32'sd1);
    send_sample(sample_t'($urandom));
    settle();
    write_threshold(24'd1);
    send_sample(last_stored());
    send_sample(last_stored() + 32'sd1);
    send_sample(last_stored() - 32'sd1);
    send_sample(last_stored());
    settle();
    write_threshold(THRESH_RESET);
    send_sample(32'sd5);
    send_sample(32'sd500);
    send_sample(32'sd1400);
    settle();
  endtask

  task automatic test_output_holdoff();
    write_threshold(24'd50000);
    stall_left = 60;
    repeat (30) send_sample(pick_sample());
    settle();
  endtask

  task automatic test_random_streams();
    logic [THRESH_W-1:0] thr;
    int                  count;
    for (int phase = 0; phase < 8; phase++) begin
      count = 200;
      case (phase)
        0: thr = THRESH_RESET;
        1: thr = THRESH_W'($urandom_range(1, 64));
        2: thr = 24'hffffff;
        3: thr = THRESH_W'($urandom);
        4: thr = THRESH_W'($urandom_range(1000, 100000));
        5: begin
          thr = 24'd0;
          count = 40;
        end
        6: thr = 24'd1;
        default: begin
          thr = THRESH_W'($urandom_range(2, 5000));
          count = 160;
        end
      endcase
      tx_gaps = (phase != 3);
      rx_gaps = (phase != 3);
      write_threshold(thr);
      repeat (count) send_sample(pick_sample());
      settle();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_priming_and_defaults();
    test_threshold_edges();
    test_output_holdoff();
    test_random_streams();
    settle();
    if (mismatches == 0) begin
      $display("glitch_rejecting_median3_filter regression: pass");
    end else begin
      $display("glitch_rejecting_median3_filter regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mf3_pkg.sv
rtl/mf3_cell.sv
rtl/mf3_median.sv
rtl/glitch_rejecting_median3_filter.sv
verif/glitch_rejecting_median3_filter_tb.sv
